// ===== hdl/tpc_pkg.sv =====
package tpc_pkg;

    localparam int NODE_COUNT    = 4096;
    localparam int ALPHABET_SIZE = 26;
    localparam int COUNT_W       = 32;
    localparam int SUM_W         = 32;
    localparam int CHAR_W        = 8;

    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int NCNT_W     = $clog2(NODE_COUNT + 1);
    localparam int TABLE_SIZE = NODE_COUNT * ALPHABET_SIZE;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int SYM_CMP_W  = CHAR_W + 1;
    localparam int SUMX_W     = ((COUNT_W > SUM_W) ? COUNT_W : SUM_W) + 1;

    localparam logic [SUM_W-1:0]  SUM_MAX       = '1;
    localparam logic [CHAR_W-1:0] OFFSET_RESET  = 8'd97;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_CHAR_OFFSET = 3'd0;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } t_opcode;

    typedef struct packed {
        logic [NODE_W-1:0]  child;
        logic [COUNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        t_entry            wr_data;
    } t_mem_req;

endpackage

// ===== hdl/tpc_cfg_regs.sv =====
module tpc_cfg_regs
    import tpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [CHAR_W-1:0]     o_char_offset
);

    logic [CHAR_W-1:0] r_char_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_offset <= OFFSET_RESET;
        end else if (psel && penable && pwrite && paddr == REG_CHAR_OFFSET) begin
            r_char_offset <= pwdata[CHAR_W-1:0];
        end
    end

    assign pready        = 1'b1;
    assign prdata        = (paddr == REG_CHAR_OFFSET) ? APB_DATA_W'(r_char_offset) : '0;
    assign o_char_offset = r_char_offset;

endmodule

// ===== hdl/tpc_node_mem.sv =====
module tpc_node_mem
    import tpc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    input  logic     i_clear_start,
    output t_entry   o_rd_data,
    output logic     o_clear_busy
);

    t_entry            mem [TABLE_SIZE];
    t_entry            r_rd_data;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_entry            wr_data;

    // zero sweep after reset and on a clear item, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (i_clear_start) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == ADDR_W'(TABLE_SIZE - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    assign wr_en   = r_clr_busy || i_req.wr_en;
    assign wr_addr = r_clr_busy ? r_clr_addr : i_req.addr;
    assign wr_data = r_clr_busy ? '0 : i_req.wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.addr];
        end
    end

    assign o_rd_data    = r_rd_data;
    assign o_clear_busy = r_clr_busy;

endmodule

// ===== hdl/tpc_walk_ctrl.sv =====
module tpc_walk_ctrl
    import tpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CHAR_W-1:0]  i_char_offset,
    input  logic               i_s_valid,
    output logic               o_s_ready,
    input  logic [1:0]         i_s_op,
    input  logic [CHAR_W-1:0]  i_s_code,
    input  logic               i_s_first,
    input  logic               i_s_last,
    output logic               o_m_valid,
    input  logic               i_m_ready,
    output logic [SUM_W-1:0]   o_m_sum,
    output logic               o_m_pool,
    output logic               o_m_bad,
    output logic               o_m_query,
    output t_mem_req           o_mem_req,
    output logic               o_clear_start,
    input  t_entry             i_mem_rd,
    input  logic               i_clear_busy
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RMW   = 3'b010,
        S_CLEAR = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [NODE_W-1:0]   r_node, n_node;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic                r_ended, n_ended;
    logic                r_pool, n_pool;
    logic                r_bad, n_bad;
    logic [NCNT_W-1:0]   r_node_cnt, n_node_cnt;
    logic                r_is_query, n_is_query;
    logic                r_last, n_last;
    logic                r_do_rmw, n_do_rmw;
    logic [ADDR_W-1:0]   r_slot, n_slot;
    logic                r_out_valid, n_out_valid;
    logic [SUM_W-1:0]    r_out_sum, n_out_sum;
    logic                r_out_pool, n_out_pool;
    logic                r_out_bad, n_out_bad;
    logic                r_out_query, n_out_query;

    logic [NODE_W-1:0]   eff_node;
    logic [SUM_W-1:0]    eff_sum;
    logic                eff_ended;
    logic                eff_pool;
    logic                eff_bad;
    logic [CHAR_W-1:0]   sym;
    logic                sym_bad;
    logic [ADDR_W-1:0]   slot;
    logic [COUNT_W-1:0]  cnt_inc;
    logic [SUMX_W-1:0]   sum_ext;
    logic [SUM_W-1:0]    sum_sat;
    logic                can_finish;
    t_opcode             in_op;

    // a first mark restarts the walk at the root
    assign eff_node  = i_s_first ? '0 : r_node;
    assign eff_sum   = i_s_first ? '0 : r_sum;
    assign eff_ended = i_s_first ? 1'b0 : r_ended;
    assign eff_pool  = i_s_first ? 1'b0 : r_pool;
    assign eff_bad   = i_s_first ? 1'b0 : r_bad;

    assign sym     = i_s_code - i_char_offset;
    assign sym_bad = {1'b0, sym} >= SYM_CMP_W'(ALPHABET_SIZE);
    assign slot    = ADDR_W'(eff_node) * ADDR_W'(ALPHABET_SIZE) + ADDR_W'(sym);
    assign in_op   = t_opcode'(i_s_op);

    assign cnt_inc = (i_mem_rd.count == '1) ? i_mem_rd.count
                                            : i_mem_rd.count + COUNT_W'(1);
    assign sum_ext = SUMX_W'(i_mem_rd.count) + SUMX_W'(r_sum);
    assign sum_sat = (sum_ext >= SUMX_W'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_W-1:0];

    assign can_finish = !r_last || !r_out_valid || i_m_ready;

    always_comb begin
        n_state       = r_state;
        n_node        = r_node;
        n_sum         = r_sum;
        n_ended       = r_ended;
        n_pool        = r_pool;
        n_bad         = r_bad;
        n_node_cnt    = r_node_cnt;
        n_is_query    = r_is_query;
        n_last        = r_last;
        n_do_rmw      = r_do_rmw;
        n_slot        = r_slot;
        n_out_valid   = r_out_valid && !i_m_ready;
        n_out_sum     = r_out_sum;
        n_out_pool    = r_out_pool;
        n_out_bad     = r_out_bad;
        n_out_query   = r_out_query;
        o_mem_req     = '0;
        o_clear_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    unique case (in_op)
                        OP_INSERT, OP_QUERY: begin
                            n_node        = eff_node;
                            n_sum         = eff_sum;
                            n_ended       = eff_ended;
                            n_pool        = eff_pool;
                            n_bad         = eff_bad || sym_bad;
                            n_is_query    = (in_op == OP_QUERY);
                            n_last        = i_s_last;
                            n_do_rmw      = !sym_bad && !eff_ended;
                            n_slot        = slot;
                            o_mem_req.rd_en = !sym_bad && !eff_ended;
                            o_mem_req.addr  = slot;
                            n_state       = S_RMW;
                        end
                        OP_CLEAR: begin
                            o_clear_start = 1'b1;
                            n_node_cnt    = NCNT_W'(1);
                            n_node        = '0;
                            n_sum         = '0;
                            n_ended       = 1'b0;
                            n_pool        = 1'b0;
                            n_bad         = 1'b0;
                            n_state       = S_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            S_RMW: begin
                if (can_finish) begin
                    if (r_do_rmw) begin
                        if (!r_is_query) begin
                            o_mem_req.addr = r_slot;
                            if (i_mem_rd.child == '0) begin
                                if (r_node_cnt >= NCNT_W'(NODE_COUNT)) begin
                                    n_pool  = 1'b1;
                                    n_ended = 1'b1;
                                end else begin
                                    n_node                  = r_node_cnt[NODE_W-1:0];
                                    n_node_cnt              = r_node_cnt + NCNT_W'(1);
                                    o_mem_req.wr_en         = 1'b1;
                                    o_mem_req.wr_data.child = r_node_cnt[NODE_W-1:0];
                                    o_mem_req.wr_data.count = cnt_inc;
                                end
                            end else begin
                                n_node                  = i_mem_rd.child;
                                o_mem_req.wr_en         = 1'b1;
                                o_mem_req.wr_data.child = i_mem_rd.child;
                                o_mem_req.wr_data.count = cnt_inc;
                            end
                        end else begin
                            n_sum = sum_sat;
                            if (i_mem_rd.child == '0) begin
                                n_ended = 1'b1;
                            end else begin
                                n_node = i_mem_rd.child;
                            end
                        end
                    end
                    if (r_last) begin
                        n_out_valid = 1'b1;
                        n_out_sum   = r_is_query ? n_sum : '0;
                        n_out_pool  = n_pool;
                        n_out_bad   = n_bad;
                        n_out_query = r_is_query;
                        n_node      = '0;
                        n_sum       = '0;
                        n_ended     = 1'b0;
                        n_pool      = 1'b0;
                        n_bad       = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            S_CLEAR: begin
                if (!i_clear_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_node      <= '0;
            r_sum       <= '0;
            r_ended     <= 1'b0;
            r_pool      <= 1'b0;
            r_bad       <= 1'b0;
            r_node_cnt  <= NCNT_W'(1);
            r_is_query  <= 1'b0;
            r_last      <= 1'b0;
            r_do_rmw    <= 1'b0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_node      <= n_node;
            r_sum       <= n_sum;
            r_ended     <= n_ended;
            r_pool      <= n_pool;
            r_bad       <= n_bad;
            r_node_cnt  <= n_node_cnt;
            r_is_query  <= n_is_query;
            r_last      <= n_last;
            r_do_rmw    <= n_do_rmw;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sum   <= n_out_sum;
        r_out_pool  <= n_out_pool;
        r_out_bad   <= n_out_bad;
        r_out_query <= n_out_query;
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_out_valid;
    assign o_m_sum   = r_out_sum;
    assign o_m_pool  = r_out_pool;
    assign o_m_bad   = r_out_bad;
    assign o_m_query = r_out_query;

endmodule

// ===== hdl/trie_prefix_count_engine.sv =====
// channel   | handshake                     | payload
// ----------+-------------------------------+---------------------------------------------
// s_axis    | s_axis_tvalid / s_axis_tready | tdata char_code, tuser opcode+first, tlast
// m_axis    | m_axis_tvalid / m_axis_tready | tdata prefix_sum, tuser pool/bad/was_query
// apb       | psel & penable & pwrite       | 0x0 char_offset
//
// Each insert or query item does a node table read in S_IDLE; an insert then
// modifies and writes back the same entry in S_RMW.
// Clear items and reset run a zero sweep over all 106496 node table entries,
// with s_axis_tready low; config writes are taken meanwhile.
// A finished result waits in the output register; the next item is accepted
// and only stalls at its write-back if it too ends a string.
module trie_prefix_count_engine
    import tpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] char_code
    input  logic [2:0]            s_axis_tuser,   // [1:0] opcode, [2] first_char
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // [31:0] prefix_sum
    output logic [2:0]            m_axis_tuser,   // [0] pool_full, [1] bad_symbol, [2] was_query
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CHAR_W-1:0] char_offset;
    t_mem_req          mem_req;
    t_entry            mem_rd;
    logic              clear_start;
    logic              clear_busy;
    logic [SUM_W-1:0]  m_sum;
    logic              m_pool;
    logic              m_bad;
    logic              m_query;

    tpc_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_char_offset (char_offset)
    );

    tpc_node_mem u_mem (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (mem_req),
        .i_clear_start (clear_start),
        .o_rd_data     (mem_rd),
        .o_clear_busy  (clear_busy)
    );

    tpc_walk_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_char_offset (char_offset),
        .i_s_valid     (s_axis_tvalid),
        .o_s_ready     (s_axis_tready),
        .i_s_op        (s_axis_tuser[1:0]),
        .i_s_code      (s_axis_tdata),
        .i_s_first     (s_axis_tuser[2]),
        .i_s_last      (s_axis_tlast),
        .o_m_valid     (m_axis_tvalid),
        .i_m_ready     (m_axis_tready),
        .o_m_sum       (m_sum),
        .o_m_pool      (m_pool),
        .o_m_bad       (m_bad),
        .o_m_query     (m_query),
        .o_mem_req     (mem_req),
        .o_clear_start (clear_start),
        .i_mem_rd      (mem_rd),
        .i_clear_busy  (clear_busy)
    );

    assign m_axis_tdata = m_sum;
    assign m_axis_tuser = {m_query, m_bad, m_pool};

endmodule

// ===== hdl/tpc_checker.sv =====
module tpc_checker
    import tpc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [2:0]            s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [31:0]           m_axis_tdata,
    input logic [2:0]            m_axis_tuser,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // every working item drops the input ready in the cycle after it is accepted
    a_item_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready &&
            (s_axis_tuser[1:0] == OP_INSERT || s_axis_tuser[1:0] == OP_QUERY ||
             s_axis_tuser[1:0] == OP_CLEAR) |=> !s_axis_tready)
        else $error("item accepted during read-modify-write");

    // clear runs a long sweep
    a_clear_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[1:0] == OP_CLEAR |=>
            !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
        else $error("input reopened during clear sweep");

    // register readback after a write
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && paddr == REG_CHAR_OFFSET ##1
            psel && !pwrite && paddr == REG_CHAR_OFFSET |->
            prdata[CHAR_W-1:0] == $past(pwdata[CHAR_W-1:0]))
        else $error("char_offset readback mismatch");

endmodule

bind trie_prefix_count_engine tpc_checker u_tpc_checker (.*);
